// File: rtl/rbc_pkg.sv
package rbc_pkg;

   // Input item field widths
   localparam int FUNC_W   = 2;
   localparam int CODE_W   = 16;
   localparam int STATUS_W = 10;
   localparam int HELD_W   = 32;
   localparam int DRAW_W   = 9;

   // Result item field widths
   localparam int OUTCOME_W = 2;
   localparam int CLASS_W   = 3;
   localparam int DELAY_W   = 17;
   localparam int DETAIL_W  = 16;
   localparam int STAGE_W   = 3;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int BASE_W      = 16;
   localparam int STAGE_REGS  = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE0      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STAGE5      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_HOLD = 3'd6;

   localparam logic [BASE_W-1:0] STAGE_DELAY_RESET [STAGE_REGS] =
      '{16'd1000, 16'd2000, 16'd4000, 16'd8000, 16'd16000, 16'd30000};
   localparam logic [HELD_W-1:0] STABLE_HOLD_RESET = 32'd60000;

   // Item kinds
   localparam logic [FUNC_W-1:0] FUNC_CLOSED  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ERROR   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TIMEOUT = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

   // Outcomes
   localparam logic [OUTCOME_W-1:0] OUTCOME_BACKOFF   = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_CFG_ERROR = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_IGNORED   = 2'd2;
   localparam logic [OUTCOME_W-1:0] OUTCOME_CLEARED   = 2'd3;

   // Failure classes
   localparam logic [CLASS_W-1:0] CLASS_NONE      = 3'd0;
   localparam logic [CLASS_W-1:0] CLASS_RETRY     = 3'd1;
   localparam logic [CLASS_W-1:0] CLASS_AUTH      = 3'd2;
   localparam logic [CLASS_W-1:0] CLASS_POLICY    = 3'd3;
   localparam logic [CLASS_W-1:0] CLASS_CERT      = 3'd4;
   localparam logic [CLASS_W-1:0] CLASS_AUTH_LOST = 3'd5;

   // Codes that end retrying
   localparam logic [STATUS_W-1:0] STATUS_UNAUTHORISED = 10'd401;
   localparam logic [STATUS_W-1:0] STATUS_FORBIDDEN    = 10'd403;
   localparam logic [CODE_W-1:0]   CLOSE_POLICY        = 16'd1008;

   // Jitter scaling: product of base and permille factor, then divide by 1000.
   // The quotient is exact for every product below 2**PRODUCT_W.
   localparam int FACTOR_W  = 11;
   localparam int PRODUCT_W = 27;
   localparam int RECIP_W   = 28;
   localparam int DIV_SHIFT = 37;
   localparam logic [RECIP_W-1:0] DIV_RECIP = 28'd137438954;

   typedef struct packed {
      logic [FUNC_W-1:0]   func;
      logic [CODE_W-1:0]   close_code;
      logic [STATUS_W-1:0] upgrade_status;
      logic                cert_error;
      logic                link_up;
      logic [HELD_W-1:0]   held_ms;
      logic [DRAW_W-1:0]   jitter_draw;
   } req_type;

   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [CLASS_W-1:0]   failure_class;
      logic [DELAY_W-1:0]   retry_delay;
      logic [DETAIL_W-1:0]  detail;
      logic [STAGE_W-1:0]   stage_used;
   } rsp_type;

   // Classified item waiting for the divide
   typedef struct packed {
      logic [OUTCOME_W-1:0] outcome;
      logic [CLASS_W-1:0]   failure_class;
      logic [PRODUCT_W-1:0] product;
      logic [DETAIL_W-1:0]  detail;
      logic [STAGE_W-1:0]   stage_used;
   } mid_type;

endpackage

// File: rtl/reconnect_backoff_classifier.sv
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    rbc_pkg::req_type
// rsp_      out        rsp_valid/stall    rbc_pkg::rsp_type
// csr_      in         csr_wr_en          csr_index, csr_wdata (no read-back)
//
// An item's result is registered in in_ff, mid_ff then rsp_ff; one item may be
// accepted every cycle while req_stall is low. The stages are an input register,
// the classify and jitter multiply, and the divide by 1000 through a reciprocal multiply.
// Reset is synchronous and restores the default stage delays and hold time.
// Each stage moves on when the stage after it is empty or moving, so a stall
// on rsp_ reaches req_stall combinationally once every stage is full.
module reconnect_backoff_classifier #(
   parameter int STAGES     = 6,
   parameter int JITTER_PCT = 20
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rbc_pkg::req_type                       req_payload,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rbc_pkg::rsp_type                       rsp_payload,
   input  logic                                   csr_wr_en,
   input  logic [rbc_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [rbc_pkg::CSR_DATA_W-1:0]         csr_wdata
);

   localparam logic [rbc_pkg::STAGE_W-1:0]  LAST_STAGE = rbc_pkg::STAGE_W'(STAGES - 1);
   localparam logic [rbc_pkg::FACTOR_W-1:0] SPAN       = rbc_pkg::FACTOR_W'(JITTER_PCT * 20);
   localparam logic [rbc_pkg::FACTOR_W-1:0] FACTOR_LOW =
      rbc_pkg::FACTOR_W'(1000 - JITTER_PCT * 10);
   localparam logic [rbc_pkg::STAGE_W-1:0]  TOP_REG    =
      rbc_pkg::STAGE_W'(rbc_pkg::STAGE_REGS - 1);

   // Configuration registers
   logic [rbc_pkg::BASE_W-1:0] stage_delay_ff [rbc_pkg::STAGE_REGS];
   logic [rbc_pkg::HELD_W-1:0] stable_hold_ff;

   // Backoff state
   logic [rbc_pkg::STAGE_W-1:0] attempt_stage_ff, attempt_stage_in;
   logic                        latch_ff, latch_in;

   // Pipeline registers
   logic             in_valid_ff, mid_valid_ff, rsp_valid_ff;
   rbc_pkg::req_type in_ff;
   rbc_pkg::mid_type mid_ff, mid_in;
   rbc_pkg::rsp_type rsp_ff, rsp_in;

   logic en_in, en_mid, en_out;

   // Working values of the classify stage
   logic [rbc_pkg::CLASS_W-1:0]  cls;
   logic [rbc_pkg::DETAIL_W-1:0] det;
   logic                         stable_reset;
   logic [rbc_pkg::STAGE_W-1:0]  idx;
   logic [rbc_pkg::STAGE_W-1:0]  reg_sel;
   logic [rbc_pkg::FACTOR_W-1:0] draw_sat;
   logic [rbc_pkg::FACTOR_W-1:0] factor;
   logic [rbc_pkg::PRODUCT_W-1:0] product;
   logic [rbc_pkg::PRODUCT_W+rbc_pkg::RECIP_W-1:0] recip_prod;

   // Stage enables: a stage moves when the next is empty or moving.
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en_mid    = !mid_valid_ff || en_out;
   assign en_in     = !in_valid_ff || en_mid;
   assign req_stall = !en_in;

   // Configuration writes; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_delay_ff <= rbc_pkg::STAGE_DELAY_RESET;
         stable_hold_ff <= rbc_pkg::STABLE_HOLD_RESET;
      end else if (csr_wr_en) begin
         if (csr_index <= rbc_pkg::CSR_STAGE5) begin
            stage_delay_ff[csr_index] <= csr_wdata[rbc_pkg::BASE_W-1:0];
         end else if (csr_index == rbc_pkg::CSR_STABLE_HOLD) begin
            stable_hold_ff <= csr_wdata;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en_in) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_in && req_valid) begin
         in_ff <= req_payload;
      end
   end

   // Classify the ending and form the jittered product.
   always_comb begin
      cls = rbc_pkg::CLASS_RETRY;
      det = '0;
      unique case (in_ff.func)
         rbc_pkg::FUNC_CLOSED: begin
            det = in_ff.close_code;
            if (in_ff.close_code == rbc_pkg::CLOSE_POLICY) begin
               cls = rbc_pkg::CLASS_AUTH_LOST;
            end
         end
         rbc_pkg::FUNC_ERROR: begin
            det = rbc_pkg::DETAIL_W'(in_ff.upgrade_status);
            if (in_ff.upgrade_status == rbc_pkg::STATUS_UNAUTHORISED) begin
               cls = rbc_pkg::CLASS_AUTH;
            end else if (in_ff.upgrade_status == rbc_pkg::STATUS_FORBIDDEN) begin
               cls = rbc_pkg::CLASS_POLICY;
            end else if (in_ff.cert_error) begin
               cls = rbc_pkg::CLASS_CERT;
            end
         end
         rbc_pkg::FUNC_TIMEOUT, rbc_pkg::FUNC_CLEAR: begin
            cls = rbc_pkg::CLASS_RETRY;
         end
         default: begin
            cls = rbc_pkg::CLASS_RETRY;
         end
      endcase

      // A long enough hold sends the backoff back to the first stage.
      stable_reset = in_ff.link_up && (in_ff.held_ms >= stable_hold_ff);
      if (stable_reset) begin
         idx = '0;
      end else if (attempt_stage_ff > LAST_STAGE) begin
         idx = LAST_STAGE;
      end else begin
         idx = attempt_stage_ff;
      end
      reg_sel = (idx > TOP_REG) ? TOP_REG : idx;

      // Jitter factor in permille, draw saturated at the full span.
      draw_sat = rbc_pkg::FACTOR_W'(in_ff.jitter_draw);
      if (draw_sat > SPAN) begin
         draw_sat = SPAN;
      end
      factor  = FACTOR_LOW + draw_sat;
      product = rbc_pkg::PRODUCT_W'(stage_delay_ff[reg_sel]) *
                rbc_pkg::PRODUCT_W'(factor);

      mid_in           = '0;
      attempt_stage_in = attempt_stage_ff;
      latch_in         = latch_ff;
      priority if (in_ff.func == rbc_pkg::FUNC_CLEAR) begin
         mid_in.outcome = rbc_pkg::OUTCOME_CLEARED;
         if (latch_ff) begin
            latch_in         = 1'b0;
            attempt_stage_in = '0;
         end
      end else if (latch_ff) begin
         mid_in.outcome = rbc_pkg::OUTCOME_IGNORED;
      end else if (cls != rbc_pkg::CLASS_RETRY) begin
         mid_in.outcome       = rbc_pkg::OUTCOME_CFG_ERROR;
         mid_in.failure_class = cls;
         mid_in.detail        = det;
         latch_in             = 1'b1;
      end else begin
         mid_in.outcome       = rbc_pkg::OUTCOME_BACKOFF;
         mid_in.failure_class = rbc_pkg::CLASS_RETRY;
         mid_in.detail        = det;
         mid_in.stage_used    = idx;
         mid_in.product       = product;
         attempt_stage_in     = (idx < LAST_STAGE) ? idx + 1'b1 : LAST_STAGE;
      end
   end

   // State changes as the item leaves the classify stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         attempt_stage_ff <= '0;
         latch_ff         <= 1'b0;
         mid_valid_ff     <= 1'b0;
      end else if (en_mid) begin
         mid_valid_ff <= in_valid_ff;
         if (in_valid_ff) begin
            attempt_stage_ff <= attempt_stage_in;
            latch_ff         <= latch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_mid && in_valid_ff) begin
         mid_ff <= mid_in;
      end
   end

   // Divide the product by 1000 with a reciprocal multiply.
   always_comb begin
      recip_prod = (rbc_pkg::PRODUCT_W + rbc_pkg::RECIP_W)'(mid_ff.product) *
                   (rbc_pkg::PRODUCT_W + rbc_pkg::RECIP_W)'(rbc_pkg::DIV_RECIP);
      rsp_in               = '0;
      rsp_in.outcome       = mid_ff.outcome;
      rsp_in.failure_class = mid_ff.failure_class;
      rsp_in.retry_delay   =
         recip_prod[rbc_pkg::DIV_SHIFT + rbc_pkg::DELAY_W - 1:rbc_pkg::DIV_SHIFT];
      rsp_in.detail        = mid_ff.detail;
      rsp_in.stage_used    = mid_ff.stage_used;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= mid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out && mid_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The stage index never passes the last stage.
   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      attempt_stage_ff <= LAST_STAGE)
      else $error("backoff stage beyond the last stage");

   // A configuration error leaving the classify stage sets the latch.
   a_latch_set: assert property (@(posedge clock) disable iff (reset)
      (en_mid && in_valid_ff && mid_in.outcome == rbc_pkg::OUTCOME_CFG_ERROR)
      |=> latch_ff)
      else $error("configuration error did not set the latch");

   // Only a backoff wait carries a delay or a stage.
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.outcome != rbc_pkg::OUTCOME_BACKOFF)
      |-> (rsp_ff.retry_delay == '0 && rsp_ff.stage_used == '0))
      else $error("delay or stage on a result that is not a backoff wait");

   // A full middle stage holds while the result is stalled.
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (mid_valid_ff && rsp_valid_ff && rsp_stall)
      |=> (mid_valid_ff && $stable(mid_ff)))
      else $error("middle stage changed under a stalled result");

endmodule

// File: sim/reconnect_backoff_classifier_tb.sv
`timescale 1ns / 100ps

module reconnect_backoff_classifier_tb;

   localparam int STAGES      = 6;
   localparam int JITTER_PCT  = 20;
   localparam int LAST_STAGE  = STAGES - 1;
   localparam int JITTER_SPAN = 2 * JITTER_PCT * 10;
   localparam int IDLE_PCT    = 29;
   localparam int MAX_REPORTS = 10;
   localparam int PHASE_ITEMS = 255;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   rbc_pkg::req_type                req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   rbc_pkg::rsp_type                rsp_payload;
   logic                            csr_wr_en   = 1'b0;
   logic [rbc_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [rbc_pkg::CSR_DATA_W-1:0]  csr_wdata   = '0;

   // Predicted configuration and state of the classifier
   logic [rbc_pkg::BASE_W-1:0] stage_base [rbc_pkg::STAGE_REGS];
   logic [rbc_pkg::HELD_W-1:0] hold_ms;
   int unsigned                backoff_stage;
   bit                         error_latched;

   // Outcomes predicted for accepted endings, oldest first
   rbc_pkg::rsp_type pending_outcomes [$];
   int               mismatch_count = 0;
   bit               gaps_on        = 1'b1;
   bit               stalls_on      = 1'b1;

   reconnect_backoff_classifier #(
      .STAGES     (STAGES),
      .JITTER_PCT (JITTER_PCT)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Back-pressure on the result channel.
   always @(posedge clock) begin
      rsp_stall <= stalls_on && ($urandom_range(99) < IDLE_PCT);
   end

   // Works out the outcome of one session ending and advances the predicted state.
   function automatic rbc_pkg::rsp_type classify_ending(input rbc_pkg::req_type item);
      rbc_pkg::rsp_type             res;
      logic [rbc_pkg::CLASS_W-1:0]  cls;
      logic [rbc_pkg::DETAIL_W-1:0] det;
      int unsigned                  idx;
      int unsigned                  draw;
      longint unsigned              base;
      longint unsigned              scaled;
      res = '0;
      cls = rbc_pkg::CLASS_RETRY;
      det = '0;
      if (item.func == rbc_pkg::FUNC_CLEAR) begin
         if (error_latched) begin
            error_latched = 1'b0;
            backoff_stage = 0;
         end
         res.outcome = rbc_pkg::OUTCOME_CLEARED;
         return res;
      end
      if (error_latched) begin
         res.outcome = rbc_pkg::OUTCOME_IGNORED;
         return res;
      end
      if (item.func == rbc_pkg::FUNC_CLOSED) begin
         det = item.close_code;
         if (item.close_code == rbc_pkg::CLOSE_POLICY) cls = rbc_pkg::CLASS_AUTH_LOST;
      end else if (item.func == rbc_pkg::FUNC_ERROR) begin
         det = rbc_pkg::DETAIL_W'(item.upgrade_status);
         if (item.upgrade_status == rbc_pkg::STATUS_UNAUTHORISED) cls = rbc_pkg::CLASS_AUTH;
         else if (item.upgrade_status == rbc_pkg::STATUS_FORBIDDEN) cls = rbc_pkg::CLASS_POLICY;
         else if (item.cert_error) cls = rbc_pkg::CLASS_CERT;
      end
      if (cls != rbc_pkg::CLASS_RETRY) begin
         error_latched     = 1'b1;
         res.outcome       = rbc_pkg::OUTCOME_CFG_ERROR;
         res.failure_class = cls;
         res.detail        = det;
         return res;
      end
      // A long enough hold restarts the backoff before the stage is used.
      if (item.link_up && item.held_ms >= hold_ms) backoff_stage = 0;
      idx = (backoff_stage > LAST_STAGE) ? LAST_STAGE : backoff_stage;
      if (backoff_stage < LAST_STAGE) backoff_stage++;
      draw   = (item.jitter_draw > JITTER_SPAN) ? JITTER_SPAN : item.jitter_draw;
      base   = stage_base[(idx > rbc_pkg::STAGE_REGS - 1) ? rbc_pkg::STAGE_REGS - 1 : idx];
      scaled = base * (1000 - JITTER_SPAN / 2 + draw) / 1000;
      res.outcome       = rbc_pkg::OUTCOME_BACKOFF;
      res.failure_class = rbc_pkg::CLASS_RETRY;
      res.retry_delay   = rbc_pkg::DELAY_W'(scaled);
      res.detail        = det;
      res.stage_used    = rbc_pkg::STAGE_W'(idx);
      return res;
   endfunction

   // Fields are shown as outcome/class/delay/detail/stage.
   function automatic void report_mismatch(input string what, input rbc_pkg::rsp_type want,
                                           input rbc_pkg::rsp_type got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                  $realtime, what, want.outcome, want.failure_class, want.retry_delay,
                  want.detail, want.stage_used, got.outcome, got.failure_class,
                  got.retry_delay, got.detail, got.stage_used);
   endfunction

   // Each result transfer is compared with the oldest predicted outcome.
   always @(posedge clock) begin
      rbc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch("unexpected result", '0, rsp_payload);
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_payload.outcome       !== want.outcome       ||
                rsp_payload.failure_class !== want.failure_class ||
                rsp_payload.retry_delay   !== want.retry_delay   ||
                rsp_payload.detail        !== want.detail        ||
                rsp_payload.stage_used    !== want.stage_used)
               report_mismatch("result mismatch", want, rsp_payload);
         end
      end
   end

   // Offers one ending, waits for its transfer and records the predicted outcome.
   task automatic send_item(input rbc_pkg::req_type item);
      if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < IDLE_PCT);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(classify_ending(item));
   endtask

   // Stops offering and waits until every predicted outcome has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rbc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [rbc_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      if (index == rbc_pkg::CSR_STABLE_HOLD) hold_ms = value;
      else if (index <= rbc_pkg::CSR_STAGE5)
         stage_base[index - rbc_pkg::CSR_STAGE0] = value[rbc_pkg::BASE_W-1:0];
   endtask

   // Loads every stage delay (a fixed fill or random values) and the stable hold time.
   task automatic program_backoff(input bit random_bases,
                                  input logic [rbc_pkg::BASE_W-1:0] fill,
                                  input logic [rbc_pkg::HELD_W-1:0] hold);
      drain_results();
      for (int i = 0; i < rbc_pkg::STAGE_REGS; i++)
         write_csr(rbc_pkg::CSR_INDEX_W'(rbc_pkg::CSR_STAGE0 + i),
                   random_bases ? $urandom_range(65535) : rbc_pkg::CSR_DATA_W'(fill));
      write_csr(rbc_pkg::CSR_STABLE_HOLD, hold);
   endtask

   function automatic rbc_pkg::req_type make_item(input logic [rbc_pkg::FUNC_W-1:0] func,
                                                  input logic [rbc_pkg::CODE_W-1:0] code,
                                                  input logic [rbc_pkg::STATUS_W-1:0] status,
                                                  input logic cert, input logic conn,
                                                  input logic [rbc_pkg::HELD_W-1:0] held,
                                                  input logic [rbc_pkg::DRAW_W-1:0] draw);
      rbc_pkg::req_type item;
      item.func           = func;
      item.close_code     = code;
      item.upgrade_status = status;
      item.cert_error     = cert;
      item.link_up        = conn;
      item.held_ms        = held;
      item.jitter_draw    = draw;
      return item;
   endfunction

   // Mostly retryable endings with random content; config errors are rare and
   // a clear usually follows soon after a latch.
   function automatic rbc_pkg::req_type random_ending();
      rbc_pkg::req_type item;
      int unsigned      pick;
      item.close_code     = ($urandom_range(99) < 5) ? rbc_pkg::CLOSE_POLICY :
                                                       rbc_pkg::CODE_W'($urandom);
      pick                = $urandom_range(99);
      item.upgrade_status = (pick < 4)  ? rbc_pkg::STATUS_UNAUTHORISED :
                            (pick < 8)  ? rbc_pkg::STATUS_FORBIDDEN :
                            (pick < 20) ? rbc_pkg::STATUS_W'($urandom_range(1023)) :
                                          rbc_pkg::STATUS_W'($urandom_range(999));
      item.cert_error     = ($urandom_range(99) < 6);
      item.link_up        = ($urandom_range(99) < 40);
      item.jitter_draw    = ($urandom_range(99) < 10) ?
                            rbc_pkg::DRAW_W'($urandom_range(511, JITTER_SPAN + 1)) :
                            rbc_pkg::DRAW_W'($urandom_range(JITTER_SPAN));
      case ($urandom_range(5))
         0: item.held_ms = hold_ms;
         1: item.held_ms = hold_ms - 1;
         2: item.held_ms = hold_ms + 1;
         3: item.held_ms = $urandom_range(hold_ms);
         4: item.held_ms = $urandom_range(1) ? '1 : '0;
         default: item.held_ms = $urandom;
      endcase
      pick = $urandom_range(99);
      if (pick < (error_latched ? 35 : 3)) begin
         item.func = rbc_pkg::FUNC_CLEAR;
      end else begin
         case ($urandom_range(2))
            0: item.func = rbc_pkg::FUNC_CLOSED;
            1: item.func = rbc_pkg::FUNC_ERROR;
            default: item.func = rbc_pkg::FUNC_TIMEOUT;
         endcase
      end
      return item;
   endfunction

   // Jitter at both ends of the draw, the centre, and draws that saturate.
   task automatic test_jitter_bounds();
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd400));
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'hFFFF, 10'd1023, 1'b1, 1'b0, 32'd0,
                          9'd511));
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd200));
      send_item(make_item(rbc_pkg::FUNC_CLOSED, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd401));
   endtask

   // The stage climbs to the last one and stays there.
   task automatic test_stage_walk();
      send_item(make_item(rbc_pkg::FUNC_ERROR, 16'd0, 10'd999, 1'b0, 1'b0, 32'd0, 9'd17));
      send_item(make_item(rbc_pkg::FUNC_CLOSED, 16'hFFFF, 10'd0, 1'b1, 1'b0, 32'd0, 9'd333));
      send_item(make_item(rbc_pkg::FUNC_ERROR, 16'd0, 10'd1023, 1'b0, 1'b0, 32'd0, 9'd256));
      send_item(make_item(rbc_pkg::FUNC_CLOSED, 16'd1007, 10'd0, 1'b0, 1'b0, 32'd0, 9'd100));
   endtask

   // A hold just short of the threshold keeps the stage; equal or above restarts it.
   task automatic test_stable_reset();
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b1, hold_ms - 1,
                          9'd50));
      send_item(make_item(rbc_pkg::FUNC_CLOSED, 16'd1009, 10'd0, 1'b0, 1'b1, hold_ms,
                          9'd300));
      send_item(make_item(rbc_pkg::FUNC_ERROR, 16'd0, 10'd402, 1'b0, 1'b0, 32'hFFFF_FFFF,
                          9'd150));
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b1, 32'hFFFF_FFFF,
                          9'd400));
   endtask

   // Each terminal error, their priority, ignoring while latched, and clearing.
   task automatic test_config_errors();
      send_item(make_item(rbc_pkg::FUNC_ERROR, 16'd0, rbc_pkg::STATUS_UNAUTHORISED, 1'b1,
                          1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b1, 32'hFFFF_FFFF,
                          9'd9));
      send_item(make_item(rbc_pkg::FUNC_CLEAR, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_ERROR, 16'd0, rbc_pkg::STATUS_FORBIDDEN, 1'b1,
                          1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_CLEAR, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_ERROR, 16'd0, 10'd0, 1'b1, 1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_CLEAR, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_CLOSED, rbc_pkg::CLOSE_POLICY, 10'd0, 1'b0, 1'b0,
                          32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_CLOSED, rbc_pkg::CLOSE_POLICY, 10'd0, 1'b0, 1'b0,
                          32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_CLEAR, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd200));
      // A clear with no latch set must leave the stage alone.
      send_item(make_item(rbc_pkg::FUNC_CLEAR, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd0));
      send_item(make_item(rbc_pkg::FUNC_TIMEOUT, 16'd0, 10'd0, 1'b0, 1'b0, 32'd0, 9'd200));
   endtask

   task automatic run_random_phase(input int unsigned count);
      int unsigned counted;
      counted = 0;
      while (counted < count) begin
         send_item(random_ending());
         if (pending_outcomes[$].outcome != rbc_pkg::OUTCOME_IGNORED) counted++;
      end
   endtask

   // Random traffic under default, maximum, minimum and random settings.
   task automatic test_random_traffic();
      run_random_phase(PHASE_ITEMS);
      program_backoff(1'b0, 16'hFFFF, 32'd0);
      // One stretch with neither gaps nor back-pressure.
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      run_random_phase(PHASE_ITEMS);
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      program_backoff(1'b0, 16'd0, 32'hFFFF_FFFF);
      run_random_phase(PHASE_ITEMS);
      program_backoff(1'b1, 16'd0, $urandom_range(200000));
      run_random_phase(PHASE_ITEMS);
   endtask

   initial begin
      for (int i = 0; i < rbc_pkg::STAGE_REGS; i++)
         stage_base[i] = rbc_pkg::STAGE_DELAY_RESET[i];
      hold_ms       = rbc_pkg::STABLE_HOLD_RESET;
      backoff_stage = 0;
      error_latched = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_jitter_bounds();
      test_stage_walk();
      test_stable_reset();
      test_config_errors();
      test_random_traffic();
      drain_results();
      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
